// ===== sv/rfcr_pkg.sv =====
// shared types and constants of the relay frame check and route block
`default_nettype none
package rfcr_pkg;
   localparam int MAX_FRAME  = 64;
   localparam int MIN_FRAME  = 10;
   localparam int REPLY_LEN  = 12;
   localparam int ADDR_W     = $clog2(MAX_FRAME);
   localparam int COUNT_W    = $clog2(MAX_FRAME + 1);
   localparam int REPLY_IDX_W = $clog2(REPLY_LEN);
   localparam int IDX_W      = (COUNT_W > REPLY_IDX_W) ? COUNT_W : REPLY_IDX_W;

   localparam logic [7:0] HEAD_BYTE = 8'h68;
   localparam logic [7:0] TAIL_BYTE = 8'h16;
   localparam logic [7:0] ALL_ONES  = 8'hFF;
   localparam logic [7:0] ONE_BYTE  = 8'h01;
   localparam logic [7:0] TWO_BYTE  = 8'h02;

   typedef enum logic [2:0] {
      ST_IGNORED = 3'd0,
      ST_FORWARD = 3'd1,
      ST_REPLY   = 3'd2,
      ST_ACK     = 3'd3,
      ST_FRAMING = 3'd4,
      ST_SUM     = 3'd5,
      ST_LENGTH  = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      REG_LOCAL    = 3'd0,
      REG_GATEWAY  = 3'd1,
      REG_ADDRESS  = 3'd2,
      REG_GW_ACK   = 3'd3,
      REG_SHOW     = 3'd4,
      REG_UNLOCK   = 3'd5,
      REG_REPLY    = 3'd6,
      REG_SELECT   = 3'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      JOB_STATUS  = 2'd0,
      JOB_FORWARD = 2'd1,
      JOB_REPLY   = 2'd2
   } job_kind_type;

   typedef struct packed {
      job_kind_type         kind;
      status_type           status;
      logic                 ack;
      logic [COUNT_W-1:0]   len;
      logic [7:0]           nxt;
      logic [7:0]           sum;
      logic [7:0]           cmd;
      logic [7:0]           fir;
      logic [7:0]           sec;
   } job_type;

   typedef struct packed {
      logic [7:0] local_address;
      logic [7:0] gateway_address;
      logic [7:0] reply_code;
   } reply_cfg_type;
endpackage
`default_nettype wire

// ===== sv/rfcr_ram.sv =====
// generic single-port-write ram with registered read
`default_nettype none
module rfcr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== sv/rfcr_front.sv =====
// front end: config registers, byte capture and frame judgement
`default_nettype none
module rfcr_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_enable,
   input  wire logic [2:0]            csr_index,
   input  wire logic [7:0]            csr_write_data,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [7:0]            req_rx_byte,
   input  wire logic                  req_frame_end,
   input  wire logic                  q_full,
   input  wire logic                  fwd_done,
   output logic                       push,
   output rfcr_pkg::job_type          job,
   output rfcr_pkg::reply_cfg_type    reply_cfg,
   output logic                       ram_we,
   output logic [rfcr_pkg::ADDR_W-1:0] ram_addr,
   output logic [7:0]                 ram_data
);
   import rfcr_pkg::*;

   logic [7:0] local_ff, gateway_ff, addr_code_ff, ack_code_ff;
   logic [7:0] show_code_ff, unlock_code_ff, reply_code_ff, select_code_ff;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [7:0]         sum_ff, sum_in;
   logic               ovf_ff, ovf_in;
   logic [7:0]         last_ff, last_in, prev_ff, prev_in;
   logic [7:0]         hdr_ff [MIN_FRAME];
   logic [7:0]         hdr_in [MIN_FRAME];
   logic [7:0]         fir_ff, fir_in, sec_ff, sec_in;
   logic               lock_ff, lock_in;

   logic               accept, room;
   logic [7:0]         verify;
   logic               tgt_ok;
   job_type            job_c;

   assign req_ready = !q_full && !lock_ff;
   assign accept    = req_valid && req_ready;
   assign room      = (count_ff < COUNT_W'(MAX_FRAME));

   assign ram_we   = accept && room;
   assign ram_addr = count_ff[ADDR_W-1:0];
   assign ram_data = req_rx_byte;

   assign reply_cfg.local_address   = local_ff;
   assign reply_cfg.gateway_address = gateway_ff;
   assign reply_cfg.reply_code      = reply_code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         local_ff       <= 8'd0;
         gateway_ff     <= 8'd1;
         addr_code_ff   <= 8'd1;
         ack_code_ff    <= 8'd2;
         show_code_ff   <= 8'd3;
         unlock_code_ff <= 8'd4;
         reply_code_ff  <= 8'd129;
         select_code_ff <= 8'd130;
      end else if (csr_write_enable) begin
         case (reg_index_type'(csr_index))
            REG_LOCAL:   local_ff       <= csr_write_data;
            REG_GATEWAY: gateway_ff     <= csr_write_data;
            REG_ADDRESS: addr_code_ff   <= csr_write_data;
            REG_GW_ACK:  ack_code_ff    <= csr_write_data;
            REG_SHOW:    show_code_ff   <= csr_write_data;
            REG_UNLOCK:  unlock_code_ff <= csr_write_data;
            REG_REPLY:   reply_code_ff  <= csr_write_data;
            REG_SELECT:  select_code_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // values as they stand once this beat is stored
   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      ovf_in   = ovf_ff;
      last_in  = last_ff;
      prev_in  = prev_ff;
      for (int k = 0; k < MIN_FRAME; k++) begin
         hdr_in[k] = hdr_ff[k];
      end
      if (room) begin
         count_in = count_ff + COUNT_W'(1);
         if (count_ff != '0) begin
            sum_in = sum_ff + req_rx_byte;
         end
         prev_in = last_ff;
         last_in = req_rx_byte;
         for (int k = 0; k < MIN_FRAME; k++) begin
            if (count_ff == COUNT_W'(k)) begin
               hdr_in[k] = req_rx_byte;
            end
         end
      end else begin
         ovf_in = 1'b1;
      end
   end

   assign verify = sum_in - last_in - prev_in;
   assign tgt_ok = (hdr_in[4] != 8'd0) && (hdr_in[4] != ALL_ONES);

   always_comb begin
      job_c        = '0;
      job_c.kind   = JOB_STATUS;
      job_c.status = ST_IGNORED;
      job_c.len    = count_in;
      job_c.cmd    = hdr_in[6];
      job_c.fir    = fir_ff;
      job_c.sec    = sec_ff;
      fir_in       = fir_ff;
      sec_in       = sec_ff;
      if (ovf_in || count_in < COUNT_W'(MIN_FRAME)) begin
         job_c.status = ST_LENGTH;
      end else if (hdr_in[0] != HEAD_BYTE || last_in != TAIL_BYTE) begin
         job_c.status = ST_FRAMING;
      end else if (verify != prev_in) begin
         job_c.status = ST_SUM;
      end else if (hdr_in[7] == 8'd0) begin
         job_c.status = ST_IGNORED;
      end else if (hdr_in[2] == local_ff && hdr_in[5] == local_ff) begin
         if (hdr_in[3] != 8'd0) begin
            job_c.kind = JOB_FORWARD;
            job_c.nxt  = hdr_in[3];
         end else if (tgt_ok) begin
            job_c.kind = JOB_FORWARD;
            job_c.nxt  = hdr_in[4];
         end
      end else if (hdr_in[3] == local_ff && hdr_in[5] == local_ff) begin
         if (tgt_ok) begin
            job_c.kind = JOB_FORWARD;
            job_c.nxt  = hdr_in[4];
         end
      end else if (hdr_in[4] == local_ff && hdr_in[5] == local_ff) begin
         if (hdr_in[6] == addr_code_ff) begin
            job_c.kind = JOB_REPLY;
            fir_in     = hdr_in[2];
            sec_in     = hdr_in[3];
            job_c.fir  = hdr_in[2];
            job_c.sec  = hdr_in[3];
         end else if (hdr_in[6] == ack_code_ff) begin
            job_c.status = ST_ACK;
            job_c.ack    = (hdr_in[8] == select_code_ff) && (hdr_in[9] == ONE_BYTE);
         end else if (hdr_in[6] == show_code_ff || hdr_in[6] == unlock_code_ff) begin
            job_c.kind = JOB_REPLY;
         end
      end
      if (job_c.kind == JOB_FORWARD) begin
         job_c.status = ST_FORWARD;
         // checksum with the next step swapped in
         job_c.sum    = verify - hdr_in[5] + job_c.nxt;
      end else if (job_c.kind == JOB_REPLY) begin
         job_c.status = ST_REPLY;
      end
   end

   assign push = accept && req_frame_end;
   assign job  = job_c;

   always_comb begin
      lock_in = lock_ff;
      if (fwd_done) begin
         lock_in = 1'b0;
      end
      if (push && job_c.kind == JOB_FORWARD) begin
         lock_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         ovf_ff   <= 1'b0;
         fir_ff   <= '0;
         sec_ff   <= '0;
         lock_ff  <= 1'b0;
      end else begin
         lock_ff <= lock_in;
         if (accept) begin
            if (req_frame_end) begin
               count_ff <= '0;
               sum_ff   <= '0;
               ovf_ff   <= 1'b0;
               fir_ff   <= fir_in;
               sec_ff   <= sec_in;
            end else begin
               count_ff <= count_in;
               sum_ff   <= sum_in;
               ovf_ff   <= ovf_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         last_ff <= last_in;
         prev_ff <= prev_in;
         for (int k = 0; k < MIN_FRAME; k++) begin
            hdr_ff[k] <= hdr_in[k];
         end
      end
   end
endmodule
`default_nettype wire

// ===== sv/rfcr_queue.sv =====
// two-entry job queue between front and back
`default_nettype none
module rfcr_queue (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  rfcr_pkg::job_type  push_job,
   output logic               full,
   input  wire logic          pop,
   output logic               not_empty,
   output rfcr_pkg::job_type  head_job
);
   import rfcr_pkg::*;

   job_type    slot_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] fill_ff;

   assign full      = (fill_ff == 2'd2);
   assign not_empty = (fill_ff != 2'd0);
   assign head_job  = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= 1'b0;
         rd_ff   <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ff <= !wr_ff;
         end
         if (pop) begin
            rd_ff <= !rd_ff;
         end
         fill_ff <= fill_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end
endmodule
`default_nettype wire

// ===== sv/rfcr_back.sv =====
// back end: walks a job and drives the result beats
`default_nettype none
module rfcr_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   q_not_empty,
   input  rfcr_pkg::job_type           q_job,
   output logic                        pop,
   input  rfcr_pkg::reply_cfg_type     reply_cfg,
   output logic [rfcr_pkg::ADDR_W-1:0] ram_rd_addr,
   input  wire logic [7:0]             ram_rd_data,
   output logic                        fwd_done,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [7:0]                  rsp_tx_byte,
   output logic                        rsp_byte_valid,
   output logic                        rsp_last,
   output logic [2:0]                  rsp_frame_status,
   output logic                        rsp_select_ack
);
   import rfcr_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_FETCH = 4'b0010,
      S_LOAD  = 4'b0100,
      S_EMIT  = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   job_type            job_ff;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               ov_ff, ov_in;
   logic [7:0]         byte_ff, byte_in;
   logic               bv_ff, bv_in, last_ff, last_in, ack_ff, ack_in;
   logic [2:0]         st_ff, st_in;

   logic               out_free;
   logic [7:0]         reply_sum, reply_nxt, reply_byte, fwd_byte;
   logic               emit_last, fwd_last;

   assign out_free    = !ov_ff || rsp_ready;
   assign ram_rd_addr = idx_ff[ADDR_W-1:0];

   assign reply_nxt = (job_ff.sec != 8'd0) ? job_ff.sec :
                      ((job_ff.fir != 8'd0) ? job_ff.fir : reply_cfg.gateway_address);
   assign reply_sum = reply_cfg.local_address + job_ff.sec + job_ff.fir
                    + reply_cfg.gateway_address + reply_nxt + reply_cfg.reply_code
                    + TWO_BYTE + job_ff.cmd + ONE_BYTE;

   always_comb begin
      case (idx_ff[REPLY_IDX_W-1:0])
         4'd0:    reply_byte = HEAD_BYTE;
         4'd1:    reply_byte = reply_cfg.local_address;
         4'd2:    reply_byte = job_ff.sec;
         4'd3:    reply_byte = job_ff.fir;
         4'd4:    reply_byte = reply_cfg.gateway_address;
         4'd5:    reply_byte = reply_nxt;
         4'd6:    reply_byte = reply_cfg.reply_code;
         4'd7:    reply_byte = TWO_BYTE;
         4'd8:    reply_byte = job_ff.cmd;
         4'd9:    reply_byte = ONE_BYTE;
         4'd10:   reply_byte = reply_sum;
         default: reply_byte = TAIL_BYTE;
      endcase
   end

   assign emit_last = (job_ff.kind == JOB_STATUS) ||
                      (idx_ff == IDX_W'(REPLY_LEN - 1));
   assign fwd_last  = (idx_ff == IDX_W'(job_ff.len) - IDX_W'(1));

   always_comb begin
      if (idx_ff == IDX_W'(5)) begin
         fwd_byte = job_ff.nxt;
      end else if (idx_ff == IDX_W'(job_ff.len) - IDX_W'(2)) begin
         fwd_byte = job_ff.sum;
      end else begin
         fwd_byte = ram_rd_data;
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      ov_in    = ov_ff && !rsp_ready;
      byte_in  = byte_ff;
      bv_in    = bv_ff;
      last_in  = last_ff;
      ack_in   = ack_ff;
      st_in    = st_ff;
      pop      = 1'b0;
      fwd_done = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (q_not_empty) begin
               pop      = 1'b1;
               idx_in   = '0;
               state_in = (q_job.kind == JOB_FORWARD) ? S_FETCH : S_EMIT;
            end
         end
         S_FETCH: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            if (out_free) begin
               ov_in   = 1'b1;
               byte_in = fwd_byte;
               bv_in   = 1'b1;
               last_in = fwd_last;
               ack_in  = 1'b0;
               st_in   = job_ff.status;
               if (fwd_last) begin
                  fwd_done = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = S_FETCH;
               end
            end
         end
         S_EMIT: begin
            if (out_free) begin
               ov_in   = 1'b1;
               bv_in   = (job_ff.kind == JOB_REPLY);
               byte_in = (job_ff.kind == JOB_REPLY) ? reply_byte : 8'd0;
               last_in = emit_last;
               ack_in  = job_ff.ack;
               st_in   = job_ff.status;
               idx_in  = idx_ff + IDX_W'(1);
               if (emit_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      byte_ff <= byte_in;
      bv_ff   <= bv_in;
      last_ff <= last_in;
      ack_ff  <= ack_in;
      st_ff   <= st_in;
      if (pop) begin
         job_ff <= q_job;
      end
   end

   assign rsp_valid        = ov_ff;
   assign rsp_tx_byte      = byte_ff;
   assign rsp_byte_valid   = bv_ff;
   assign rsp_last         = last_ff;
   assign rsp_frame_status = st_ff;
   assign rsp_select_ack   = ack_ff;
endmodule
`default_nettype wire

// ===== sv/relay_frame_check_and_route.sv =====
// a frame is judged on its end beat and its job is queued; the back end pops it when idle
// and registers status or reply beats from the emit state, forwarded beats via fetch and load
// status and reply beats go out one per cycle unless stalled; forwarded beats each wait for a ram read
// frame bytes are taken one per cycle unless the queue is full or a forward is still being sent
// a two-job queue lets the next frame's bytes arrive while a reply or status waits
// synchronous active-high reset clears counters, relay path, queue and state; config to defaults
`default_nettype none
module relay_frame_check_and_route (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_write_enable,
   input  wire logic [2:0] csr_index,
   input  wire logic [7:0] csr_write_data,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       req_frame_end,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_tx_byte,
   output logic            rsp_byte_valid,
   output logic            rsp_last,
   output logic [2:0]      rsp_frame_status,
   output logic            rsp_select_ack
);
   import rfcr_pkg::*;

   logic               push, q_full, q_not_empty, pop, fwd_done, ram_we;
   job_type            push_job, head_job;
   reply_cfg_type      reply_cfg;
   logic [ADDR_W-1:0]  ram_wr_addr, ram_rd_addr;
   logic [7:0]         ram_wr_data, ram_rd_data;

   rfcr_front u_front (
      .clock, .reset, .csr_write_enable, .csr_index, .csr_write_data,
      .req_valid, .req_ready, .req_rx_byte, .req_frame_end,
      .q_full, .fwd_done, .push, .job(push_job), .reply_cfg,
      .ram_we, .ram_addr(ram_wr_addr), .ram_data(ram_wr_data)
   );

   rfcr_ram #(.WIDTH(8), .DEPTH(MAX_FRAME)) u_ram (
      .clock, .wr_en(ram_we), .wr_addr(ram_wr_addr), .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr), .rd_data(ram_rd_data)
   );

   rfcr_queue u_queue (
      .clock, .reset, .push, .push_job, .full(q_full),
      .pop, .not_empty(q_not_empty), .head_job
   );

   rfcr_back u_back (
      .clock, .reset, .q_not_empty, .q_job(head_job), .pop, .reply_cfg,
      .ram_rd_addr, .ram_rd_data, .fwd_done,
      .rsp_valid, .rsp_ready, .rsp_tx_byte, .rsp_byte_valid, .rsp_last,
      .rsp_frame_status, .rsp_select_ack
   );
endmodule
`default_nettype wire

// ===== sv/rfcr_checker.sv =====
// port-level checks of the result channel, bound to the top level
`default_nettype none
module rfcr_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_tx_byte,
   input wire logic       rsp_byte_valid,
   input wire logic       rsp_last,
   input wire logic [2:0] rsp_frame_status,
   input wire logic       rsp_select_ack
);
   import rfcr_pkg::*;

   // a stalled beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tx_byte) && $stable(rsp_last))
      else $error("stalled result beat changed");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_last && rsp_tx_byte == 8'd0)
      else $error("status-only beat not last");

   a_frame_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_valid |->
         rsp_frame_status == ST_FORWARD || rsp_frame_status == ST_REPLY)
      else $error("frame byte with wrong status");

   a_ack_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_select_ack |-> rsp_frame_status == ST_ACK && !rsp_byte_valid)
      else $error("select ack outside ack status");
endmodule

bind relay_frame_check_and_route rfcr_checker u_checker (
   .clock, .reset, .rsp_valid, .rsp_ready, .rsp_tx_byte, .rsp_byte_valid,
   .rsp_last, .rsp_frame_status, .rsp_select_ack
);
`default_nettype wire

// ===== tb/relay_frame_check_and_route_test.sv =====
// testbench of the relay frame check and route block: frame stimulus, predictor and checker
module relay_frame_check_and_route_test;
   import rfcr_pkg::*;

   typedef struct {
      logic [7:0] data;
      logic       fin;
   } rx_beat_type;

   typedef struct {
      logic [7:0] tx;
      logic       bv;
      logic       lst;
      status_type st;
      logic       ack;
   } tx_beat_type;

   typedef enum {
      FR_RELAY1, FR_RELAY2, FR_TARGET, FR_ACK, FR_STRANGER, FR_BAD_HEAD, FR_BAD_TAIL,
      FR_BAD_SUM, FR_ZERO_LEN, FR_SHORT, FR_OVERSIZE, FR_RELAY_BAD_TGT
   } frame_kind_type;

   localparam int CYCLE_LIMIT = 400000;

   logic       clock = 0;
   logic       reset = 1;
   logic       csr_write_enable = 0;
   logic [2:0] csr_index = '0;
   logic [7:0] csr_write_data = '0;
   logic       req_valid = 0;
   logic       req_ready;
   logic [7:0] req_rx_byte = '0;
   logic       req_frame_end = 0;
   logic       rsp_valid;
   logic       rsp_ready = 0;
   logic [7:0] rsp_tx_byte;
   logic       rsp_byte_valid;
   logic       rsp_last;
   logic [2:0] rsp_frame_status;
   logic       rsp_select_ack;

   relay_frame_check_and_route uut (.*);

   // predictor copy of the node
   logic [7:0] node_reg [8];
   logic [7:0] rx_store [64];
   int         rx_count;
   logic [7:0] rx_sum;
   logic [7:0] path_first, path_second;
   logic       rx_overflow;

   rx_beat_type pending_beats[$];
   tx_beat_type awaited_beats[$];
   int errors = 0, frames_sent = 0, beats_checked = 0, cycles = 0;
   logic req_fire = 0;
   logic long_hold_armed = 0, long_hold_done = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void push_status(status_type st, logic ack);
      awaited_beats.push_back('{8'h00, 1'b0, 1'b1, st, ack});
   endfunction

   function automatic void push_frame(logic [7:0] fb[$], status_type st);
      for (int i = 0; i < fb.size(); i++)
         awaited_beats.push_back('{fb[i], 1'b1, i == fb.size() - 1, st, 1'b0});
   endfunction

   function automatic void push_forward(int len, logic [7:0] hop);
      logic [7:0] fb[$];
      logic [7:0] s = 0;
      rx_store[5] = hop;
      for (int i = 1; i + 2 < len; i++) s += rx_store[i];
      rx_store[len-2] = s;
      for (int i = 0; i < len; i++) fb.push_back(rx_store[i]);
      push_frame(fb, ST_FORWARD);
   endfunction

   function automatic void push_reply(logic [7:0] cmd);
      logic [7:0] r[$];
      logic [7:0] s = 0;
      r = {HEAD_BYTE, node_reg[REG_LOCAL], path_second, path_first, node_reg[REG_GATEWAY],
           path_second != 0 ? path_second : (path_first != 0 ? path_first : node_reg[REG_GATEWAY]),
           node_reg[REG_REPLY], TWO_BYTE, cmd, ONE_BYTE};
      for (int i = 1; i < 10; i++) s += r[i];
      r.push_back(s);
      r.push_back(TAIL_BYTE);
      push_frame(r, ST_REPLY);
   endfunction

   function automatic void judge_frame(int len);
      logic [7:0] fir, sec, tgt, nxt, cmd, me;
      logic tgt_ok;
      if (rx_overflow || len < MIN_FRAME || len > MAX_FRAME) begin
         push_status(ST_LENGTH, 0);
         return;
      end
      if (rx_store[0] != HEAD_BYTE || rx_store[len-1] != TAIL_BYTE) begin
         push_status(ST_FRAMING, 0);
         return;
      end
      if (8'(rx_sum - rx_store[len-1] - rx_store[len-2]) != rx_store[len-2]) begin
         push_status(ST_SUM, 0);
         return;
      end
      if (rx_store[7] == 0) begin
         push_status(ST_IGNORED, 0);
         return;
      end
      fir = rx_store[2]; sec = rx_store[3]; tgt = rx_store[4];
      nxt = rx_store[5]; cmd = rx_store[6]; me = node_reg[REG_LOCAL];
      tgt_ok = tgt != 8'h00 && tgt != ALL_ONES;
      if (fir == me && nxt == me) begin
         if (sec != 0) push_forward(len, sec);
         else if (tgt_ok) push_forward(len, tgt);
         else push_status(ST_IGNORED, 0);
         return;
      end
      if (sec == me && nxt == me) begin
         if (tgt_ok) push_forward(len, tgt);
         else push_status(ST_IGNORED, 0);
         return;
      end
      if (tgt == me && nxt == me) begin
         if (cmd == node_reg[REG_ADDRESS]) begin
            path_first = fir;
            path_second = sec;
            push_reply(cmd);
            return;
         end
         if (cmd == node_reg[REG_GW_ACK]) begin
            push_status(ST_ACK, rx_store[8] == node_reg[REG_SELECT] && rx_store[9] == ONE_BYTE);
            return;
         end
         if (cmd == node_reg[REG_SHOW] || cmd == node_reg[REG_UNLOCK]) begin
            push_reply(cmd);
            return;
         end
      end
      push_status(ST_IGNORED, 0);
   endfunction

   function automatic void take_beat(logic [7:0] b, logic fin);
      if (rx_count < MAX_FRAME) begin
         rx_store[rx_count] = b;
         if (rx_count != 0) rx_sum += b;
         rx_count++;
      end else begin
         rx_overflow = 1;
      end
      if (fin) begin
         judge_frame(rx_count);
         rx_count = 0;
         rx_sum = 0;
         rx_overflow = 0;
      end
   endfunction

   function automatic logic [7:0] pick_code();
      case ($urandom_range(0, 5))
         0: return node_reg[REG_ADDRESS];
         1: return node_reg[REG_GW_ACK];
         2: return node_reg[REG_SHOW];
         3: return node_reg[REG_UNLOCK];
         default: return 8'($urandom);
      endcase
   endfunction

   // builds one frame of the given kind and queues its beats
   function automatic void queue_frame(frame_kind_type kind, int body_len);
      logic [7:0] fb[$];
      logic [7:0] me = node_reg[REG_LOCAL];
      logic [7:0] s = 0;
      int len;
      fb = {HEAD_BYTE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
            pick_code(), 8'($urandom_range(1, 255))};
      for (int i = 0; i < body_len; i++) fb.push_back(8'($urandom));
      case (kind)
         FR_RELAY1: begin
            fb[2] = me; fb[5] = me;
            if ($urandom_range(0, 1)) fb[3] = 0;
         end
         FR_RELAY2: begin
            fb[3] = me; fb[5] = me;
         end
         FR_RELAY_BAD_TGT: begin
            fb[2] = me; fb[5] = me; fb[3] = 0;
            fb[4] = $urandom_range(0, 1) ? ALL_ONES : 8'h00;
         end
         FR_TARGET: begin
            fb[4] = me; fb[5] = me;
         end
         FR_ACK: begin
            fb[4] = me; fb[5] = me; fb[6] = node_reg[REG_GW_ACK];
            if (fb.size() < 10) begin
               fb.push_back(0);
               fb.push_back(0);
            end
            if ($urandom_range(0, 2) != 0) fb[8] = node_reg[REG_SELECT];
            if ($urandom_range(0, 2) != 0) fb[9] = ONE_BYTE;
         end
         FR_ZERO_LEN: begin
            fb[4] = me; fb[5] = me; fb[7] = 0;
         end
         default: ;
      endcase
      for (int i = 1; i < fb.size(); i++) s += fb[i];
      fb.push_back(s);
      fb.push_back(TAIL_BYTE);
      case (kind)
         FR_BAD_HEAD: fb[0] = 8'($urandom_range(0, 1) ? 8'h00 : 8'h69);
         FR_BAD_TAIL: fb[fb.size()-1] = ~TAIL_BYTE;
         FR_BAD_SUM:  fb[fb.size()-2] = fb[fb.size()-2] + 8'($urandom_range(1, 255));
         FR_SHORT:    fb = fb[0:$urandom_range(0, 8)];
         FR_OVERSIZE: while (fb.size() < MAX_FRAME + 1 + $urandom_range(0, 4))
                         fb.insert(8, 8'($urandom));
         default: ;
      endcase
      len = fb.size();
      for (int i = 0; i < len; i++) pending_beats.push_back('{fb[i], i == len - 1});
      frames_sent++;
   endfunction

   task automatic write_reg(reg_index_type idx, logic [7:0] value);
      @(negedge clock);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= value;
      node_reg[idx] = value;
      @(negedge clock);
      csr_write_enable <= 0;
   endtask

   task automatic write_all(logic [7:0] v[8]);
      for (int i = 0; i < 8; i++) write_reg(reg_index_type'(i), v[i]);
   endtask

   task automatic wait_idle();
      while (pending_beats.size() != 0 || req_valid || awaited_beats.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic random_frames(int n);
      int dl;
      for (int i = 0; i < n; i++) begin
         dl = $urandom_range(0, 4);
         if ($urandom_range(0, 3) != 0)
            queue_frame(frame_kind_type'($urandom_range(FR_RELAY1, FR_ACK)), dl);
         else
            queue_frame(frame_kind_type'($urandom_range(FR_RELAY1, FR_RELAY_BAD_TGT)), dl);
      end
   endtask

   // sender: bursts of random length with random gaps
   int burst_left = 4, gap_left = 0;
   always @(negedge clock) begin
      rx_beat_type nb;
      if (reset) begin
         req_valid <= 0;
      end else if (!req_valid || req_fire) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 0;
         end else if (pending_beats.size() != 0) begin
            nb = pending_beats.pop_front();
            req_valid <= 1;
            req_rx_byte <= nb.data;
            req_frame_end <= nb.fin;
            if (--burst_left <= 0) begin
               burst_left = $urandom_range(1, 20);
               gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 0;
         end
      end
   end

   // receiver: rotating stall pattern, one long hold-off when armed
   logic [15:0] stall_pattern = 16'hFFFF;
   int hold_count = 0, pattern_age = 0;
   always @(negedge clock) begin
      if (long_hold_armed && !long_hold_done) begin
         if (hold_count < 300) begin
            hold_count++;
            rsp_ready <= 0;
         end else begin
            long_hold_done <= 1;
            rsp_ready <= 1;
         end
      end else begin
         if (++pattern_age == 48) begin
            pattern_age = 0;
            stall_pattern = $urandom_range(0, 2) == 0 ? 16'hFFFF : 16'($urandom);
         end
         stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
         rsp_ready <= stall_pattern[0];
      end
   end

   // checker and predictor update
   always @(posedge clock) begin
      tx_beat_type e;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d beats still awaited", $time, awaited_beats.size());
         $display("== FAIL ==");
         $finish;
      end
      req_fire <= req_valid && req_ready && !reset;
      if (!reset && rsp_valid && rsp_ready) begin
         beats_checked++;
         if (awaited_beats.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat, actual tx %h bv %b last %b st %0d ack %b", $time,
                     rsp_tx_byte, rsp_byte_valid, rsp_last, rsp_frame_status, rsp_select_ack);
         end else begin
            e = awaited_beats.pop_front();
            if (rsp_tx_byte !== e.tx || rsp_byte_valid !== e.bv || rsp_last !== e.lst ||
                rsp_frame_status !== e.st || rsp_select_ack !== e.ack) begin
               errors++;
               $display("%0t: mismatch expected tx %h bv %b last %b st %0d ack %b", $time,
                        e.tx, e.bv, e.lst, e.st, e.ack);
               $display("%0t:          actual   tx %h bv %b last %b st %0d ack %b", $time,
                        rsp_tx_byte, rsp_byte_valid, rsp_last, rsp_frame_status,
                        rsp_select_ack);
            end
         end
      end
      if (!reset && req_valid && req_ready) take_beat(req_rx_byte, req_frame_end);
   end

   initial begin
      node_reg = '{8'd0, 8'd1, 8'd1, 8'd2, 8'd3, 8'd4, 8'd129, 8'd130};
      rx_count = 0; rx_sum = 0; rx_overflow = 0; path_first = 0; path_second = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: short frame and ack at defaults
      queue_frame(FR_SHORT, 0);
      queue_frame(FR_ACK, 0);
      wait_idle();

      // node address at the top, duplicate codes to exercise command priority
      write_all('{8'hFF, 8'h00, 8'h55, 8'h55, 8'h55, 8'hFF, 8'hFF, 8'hFF});
      queue_frame(FR_OVERSIZE, 0);
      random_frames(1);
      wait_idle();

      // long hold-off on the result side while replies and relays keep coming
      write_all('{8'h3C, 8'h80, 8'h10, 8'h20, 8'h30, 8'h40, 8'hA5, 8'h01});
      long_hold_armed = 1;
      for (int i = 0; i < 2; i++) queue_frame(FR_TARGET, 0);
      queue_frame(FR_RELAY1, 0);
      queue_frame(FR_RELAY2, 0);
      wait_idle();

      $display("frames sent %0d, result beats checked %0d over 3 register settings",
               frames_sent, beats_checked);
      $display("covered relays, replies, acks, length faults and a long result stall");
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d errors", errors);
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
sv/rfcr_pkg.sv
sv/rfcr_ram.sv
sv/rfcr_front.sv
sv/rfcr_queue.sv
sv/rfcr_back.sv
sv/relay_frame_check_and_route.sv
sv/rfcr_checker.sv
tb/relay_frame_check_and_route_test.sv
